[src/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and constants of the gyro bias calibrator
// Field widths, item kinds, status codes, back-end states and helpers.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 16;
    localparam int TH_W     = 16;
    localparam int YAW_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES = 3;
    localparam int DATA_W   = NUM_AXES * SAMPLE_W;
    localparam int SUM_W    = SAMPLE_W + COUNT_W;
    localparam int SQ_W     = 2 * SAMPLE_W + COUNT_W;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 96;
    localparam int DIVD_W   = SUM_W + 1;
    localparam int SAT_W    = SAMPLE_W + 3;
    localparam int STAT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_TH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_OFFSET  = 2'd2;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_RAW       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_CAL       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MOTION    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CORRECTED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_COMPLETE  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CMD_DONE  = 3'd5;

    localparam logic [COUNT_W-1:0] CAL_SAMPLES_RST = 16'd800;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_RESTART,
        KIND_LOAD,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t                              kind;
        logic [NUM_AXES-1:0][SAMPLE_W-1:0]  axis;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ADD,
        S_K_MUL,
        S_K_WR,
        S_MV_MUL,
        S_MV_ADD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        OUT_RAW,
        OUT_CORR,
        OUT_ZERO
    } out_mode_t;

    function automatic logic [SAT_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v);
        sext_sample = {{(SAT_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // clamp to the signed sample range
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAT_W-1:0] v);
        logic [SAT_W-SAMPLE_W:0] top;
        top = v[SAT_W-1:SAMPLE_W-1];
        if ((top == '0) || (top == '1))
            sat_sample = v[SAMPLE_W-1:0];
        else if (v[SAT_W-1])
            sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

[src/gyro_bias_calibrator_core.sv]
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_core: gyro zero-offset calibration with motion check
// Input beats carry an operation in tuser and three axis rates in tdata.
// Result beats carry a status in tuser and three output rates in tdata.
// A two-entry queue sits between the decode front end and the back end;
// results leave through a registered output stage, so a stalled receiver
// holds the result register and the back end while the queue keeps filling.
// Commands, and samples outside calibration, go straight to the result
// register; each calibration sample runs three squares on the shared 32x32
// multiplier; the final one adds the motion check when enabled and then
// three 41-step divisions unless motion is found. While one beat is worked
// on, the queue still takes up to two more.
// After reset the block calibrates over 800 samples with the motion check
// off. Configuration writes are taken at any edge with cfg_we high and
// must be issued only while no beat is in flight.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gbc_pkg::DATA_W-1:0]       s_axis_tdata,  // axis_x, axis_y, axis_z
    input  logic [1:0]                       s_axis_tuser,  // operation
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gbc_pkg::DATA_W-1:0]       m_axis_tdata,  // out_x, out_y, out_z
    output logic [gbc_pkg::STAT_W-1:0]       m_axis_tuser   // status
);
    import gbc_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_pop;

    gbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_op       (s_axis_tuser),
        .s_data     (s_axis_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    gbc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_status   (m_axis_tuser),
        .m_data     (m_axis_tdata)
    );

endmodule

[src/gbc_front.sv]
// ----------------------------------------------------------------------------
// gbc_front: input acceptance and classification
// Takes input beats, decodes the operation and queues items for the back end.
// ----------------------------------------------------------------------------
module gbc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic [gbc_pkg::DATA_W-1:0]     s_data,
    output logic                           item_valid,
    output gbc_pkg::item_t                 item,
    input  logic                           item_pop
);
    import gbc_pkg::*;

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      in_item;
    logic       push;

    always_comb begin
        in_item.axis = s_data;
        unique case (s_op)
            OP_SAMPLE:  in_item.kind = KIND_SAMPLE;
            OP_RESTART: in_item.kind = KIND_RESTART;
            OP_LOAD:    in_item.kind = KIND_LOAD;
            default:    in_item.kind = KIND_NOP;
        endcase
    end

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ item_pop;
        count_next  = count_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[src/gbc_div.sv]
// ----------------------------------------------------------------------------
// gbc_div: restoring divider
// Unsigned dividend by count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [gbc_pkg::DIVD_W-1:0]   dividend,
    input  logic [gbc_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic [gbc_pkg::DIVD_W-1:0]   quotient
);
    import gbc_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0]  quo_reg, quo_next;
    logic [COUNT_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W+1:0] diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[COUNT_W+1]) begin
                rem_next = trial[COUNT_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end else begin
                rem_next = diff[COUNT_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/gbc_back.sv]
// ----------------------------------------------------------------------------
// gbc_back: calibration engine and output stage
// Accumulates sums, runs the motion check on a shared multiplier, forms the
// rounded means on the divider and drives the result register.
// ----------------------------------------------------------------------------
module gbc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            item_valid,
    input  gbc_pkg::item_t                  item,
    output logic                            item_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbc_pkg::STAT_W-1:0]      m_status,
    output logic [gbc_pkg::DATA_W-1:0]      m_data
);
    import gbc_pkg::*;

    localparam logic [2:0] MV_LAST = 3'd5;
    localparam logic [1:0] K_LAST  = 2'd2;
    localparam logic [1:0] AXIS_Z  = 2'd2;

    // configuration
    logic [COUNT_W-1:0] cal_samples_reg;
    logic [TH_W-1:0]    motion_th_reg;
    logic [YAW_W-1:0]   yaw_reg;

    // calibration state
    logic [SUM_W-1:0]    sum_reg  [NUM_AXES];
    logic [SQ_W-1:0]     sq_reg   [NUM_AXES];
    logic [SAMPLE_W-1:0] zero_reg [NUM_AXES];
    logic [COUNT_W-1:0]  samples_left_reg;
    logic                calibrating_reg;
    logic                calibrated_reg;

    // working registers
    back_state_t         state_reg, state_next;
    logic [1:0]          ax_reg;
    logic [2:0]          sub_reg;
    logic [1:0]          kstep_reg;
    logic [SAMPLE_W-1:0] raw_reg [NUM_AXES];
    out_mode_t           mode_reg;
    logic [STAT_W-1:0]   stat_reg;
    logic                moving_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MUL_W-1:0]    tt_reg;
    logic [MUL_W-1:0]    nn_reg;
    logic [PROD_W-1:0]   k_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;

    // datapath
    logic [COUNT_W-1:0]  n_eff;
    logic [SAMPLE_W-1:0] raw_ax;
    logic [SAMPLE_W-1:0] raw_mag;
    logic [SUM_W-1:0]    sum_cur;
    logic [SUM_W-1:0]    sum_mag;
    logic [SQ_W-1:0]     sq_cur;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]    acc_step;
    logic                acc_pos;
    logic                check_on;
    logic                out_free;
    logic                div_start;
    logic                div_done;
    logic [DIVD_W-1:0]   div_quo;
    logic [DIVD_W-1:0]   div_dividend;
    logic [SAMPLE_W:0]   mean_mag;
    logic [SAMPLE_W:0]   mean;
    logic [SAT_W-1:0]    zdiff;
    logic [SAMPLE_W-1:0] zval;
    logic [DATA_W-1:0]   emit_data;

    assign n_eff    = (cal_samples_reg == '0) ? COUNT_W'(1) : cal_samples_reg;
    assign raw_ax   = raw_reg[ax_reg];
    assign raw_mag  = raw_ax[SAMPLE_W-1] ? (~raw_ax + 1'b1) : raw_ax;
    assign sum_cur  = sum_reg[ax_reg];
    assign sum_mag  = sum_cur[SUM_W-1] ? (~sum_cur + 1'b1) : sum_cur;
    assign sq_cur   = sq_reg[ax_reg];
    assign check_on = (motion_th_reg != '0) && (cal_samples_reg > COUNT_W'(1));
    assign out_free = !out_valid_reg || m_ready;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ_MUL: begin
                mul_a = MUL_W'(raw_mag);
                mul_b = MUL_W'(raw_mag);
            end
            S_K_MUL: begin
                case (kstep_reg)
                    2'd0: begin
                        mul_a = MUL_W'(motion_th_reg);
                        mul_b = MUL_W'(motion_th_reg);
                    end
                    2'd1: begin
                        mul_a = MUL_W'(n_eff);
                        mul_b = MUL_W'(n_eff - 1'b1);
                    end
                    default: begin
                        mul_a = tt_reg;
                        mul_b = nn_reg;
                    end
                endcase
            end
            S_MV_MUL: begin
                // n*sumsq - |sum|^2, split into 32-bit partial products
                case (sub_reg)
                    3'd0: begin
                        mul_a = MUL_W'(n_eff);
                        mul_b = sq_cur[MUL_W-1:0];
                    end
                    3'd1: begin
                        mul_a = MUL_W'(n_eff);
                        mul_b = sq_cur[SQ_W-1:MUL_W];
                    end
                    3'd2: begin
                        mul_a = sum_mag[MUL_W-1:0];
                        mul_b = sum_mag[MUL_W-1:0];
                    end
                    3'd3: begin
                        mul_a = sum_mag[MUL_W-1:0];
                        mul_b = MUL_W'(sum_mag[SUM_W-1:MUL_W]);
                    end
                    3'd4: begin
                        mul_a = MUL_W'(sum_mag[SUM_W-1:MUL_W]);
                        mul_b = MUL_W'(sum_mag[SUM_W-1:MUL_W]);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        case (sub_reg)
            3'd0:    acc_step = prod_ext;
            3'd1:    acc_step = acc_reg + (prod_ext << MUL_W);
            3'd2:    acc_step = acc_reg - prod_ext;
            3'd3:    acc_step = acc_reg - (prod_ext << (MUL_W + 1));
            3'd4:    acc_step = acc_reg - (prod_ext << PROD_W);
            default: acc_step = acc_reg - ACC_W'(k_reg);
        endcase
    end

    assign acc_pos = !acc_step[ACC_W-1] && (acc_step != '0);

    // rounded mean: (|sum| + n/2) / n, sign restored
    assign div_dividend = DIVD_W'(sum_mag) + DIVD_W'(n_eff >> 1);
    assign mean_mag     = div_quo[SAMPLE_W:0];
    assign mean         = sum_cur[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
    assign zdiff        = {{(SAT_W-SAMPLE_W-1){mean[SAMPLE_W]}}, mean}
                        - {{(SAT_W-YAW_W){yaw_reg[YAW_W-1]}}, yaw_reg};
    assign zval         = (ax_reg == AXIS_Z) ? sat_sample(zdiff) : mean[SAMPLE_W-1:0];

    gbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result payload
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            case (mode_reg)
                OUT_RAW:  emit_data[i*SAMPLE_W +: SAMPLE_W] = raw_reg[i];
                OUT_CORR: emit_data[i*SAMPLE_W +: SAMPLE_W] =
                    sat_sample(sext_sample(raw_reg[i]) - sext_sample(zero_reg[i]));
                default:  emit_data[i*SAMPLE_W +: SAMPLE_W] = '0;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    if ((item.kind == KIND_SAMPLE) && calibrating_reg)
                        state_next = S_SQ_MUL;
                    else
                        state_next = S_EMIT;
                end
            end
            S_SQ_MUL: state_next = S_SQ_ADD;
            S_SQ_ADD: begin
                if (ax_reg != AXIS_Z)
                    state_next = S_SQ_MUL;
                else if (samples_left_reg > COUNT_W'(1))
                    state_next = S_EMIT;
                else if (check_on)
                    state_next = S_K_MUL;
                else
                    state_next = S_DIV_GO;
            end
            S_K_MUL: state_next = S_K_WR;
            S_K_WR:  state_next = (kstep_reg == K_LAST) ? S_MV_MUL : S_K_MUL;
            S_MV_MUL: state_next = S_MV_ADD;
            S_MV_ADD: begin
                if (sub_reg != MV_LAST)
                    state_next = S_MV_MUL;
                else if (ax_reg != AXIS_Z)
                    state_next = S_MV_MUL;
                else if (moving_reg || acc_pos)
                    state_next = S_EMIT;
                else
                    state_next = S_DIV_GO;
            end
            S_DIV_GO: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done)
                    state_next = (ax_reg == AXIS_Z) ? S_EMIT : S_DIV_GO;
            end
            S_EMIT: begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        item_pop  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:   item_pop  = item_valid;
            S_DIV_GO: div_start = 1'b1;
            default: begin
                item_pop  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // calibration state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg  <= CAL_SAMPLES_RST;
            motion_th_reg    <= '0;
            yaw_reg          <= '0;
            samples_left_reg <= CAL_SAMPLES_RST;
            calibrating_reg  <= 1'b1;
            calibrated_reg   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                sum_reg[i]  <= '0;
                sq_reg[i]   <= '0;
                zero_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (item_valid) begin
                        case (item.kind)
                            KIND_RESTART: begin
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    sum_reg[i]  <= '0;
                                    sq_reg[i]   <= '0;
                                    zero_reg[i] <= '0;
                                end
                                samples_left_reg <= n_eff;
                                calibrating_reg  <= 1'b1;
                                calibrated_reg   <= 1'b0;
                            end
                            KIND_LOAD: begin
                                for (int i = 0; i < NUM_AXES; i++)
                                    zero_reg[i] <= item.axis[i];
                                calibrating_reg <= 1'b0;
                                calibrated_reg  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SQ_ADD: begin
                    sum_reg[ax_reg] <= sum_cur + {{(SUM_W-SAMPLE_W){raw_ax[SAMPLE_W-1]}}, raw_ax};
                    sq_reg[ax_reg]  <= sq_cur + SQ_W'(prod_reg);
                    if ((ax_reg == AXIS_Z) && (samples_left_reg > COUNT_W'(1)))
                        samples_left_reg <= samples_left_reg - 1'b1;
                end
                S_MV_ADD: begin
                    if ((sub_reg == MV_LAST) && (ax_reg == AXIS_Z) && (moving_reg || acc_pos)) begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                            sum_reg[i] <= '0;
                            sq_reg[i]  <= '0;
                        end
                        samples_left_reg <= n_eff;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        zero_reg[ax_reg] <= zval;
                        if (ax_reg == AXIS_Z) begin
                            calibrating_reg  <= 1'b0;
                            calibrated_reg   <= 1'b1;
                            samples_left_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase

            if (cfg_we) begin
                case (cfg_index)
                    REG_CAL_SAMPLES: begin
                        cal_samples_reg <= cfg_wdata;
                        if (calibrating_reg) begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                sum_reg[i] <= '0;
                                sq_reg[i]  <= '0;
                            end
                            samples_left_reg <= (cfg_wdata == '0) ? COUNT_W'(1) : cfg_wdata;
                        end
                    end
                    REG_MOTION_TH:  motion_th_reg <= cfg_wdata;
                    REG_YAW_OFFSET: yaw_reg       <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg     <= '0;
            sub_reg    <= '0;
            kstep_reg  <= '0;
            moving_reg <= 1'b0;
            mode_reg   <= OUT_RAW;
            stat_reg   <= STAT_RAW;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (item_valid) begin
                        for (int i = 0; i < NUM_AXES; i++)
                            raw_reg[i] <= item.axis[i];
                        ax_reg <= '0;
                        if (item.kind == KIND_SAMPLE) begin
                            if (!calibrating_reg) begin
                                mode_reg <= calibrated_reg ? OUT_CORR : OUT_RAW;
                                stat_reg <= calibrated_reg ? STAT_CORRECTED : STAT_RAW;
                            end
                        end else begin
                            mode_reg <= OUT_ZERO;
                            stat_reg <= STAT_CMD_DONE;
                        end
                    end
                end
                S_SQ_MUL: prod_reg <= mul_p;
                S_SQ_ADD: begin
                    if (ax_reg == AXIS_Z) begin
                        ax_reg     <= '0;
                        sub_reg    <= '0;
                        kstep_reg  <= '0;
                        moving_reg <= 1'b0;
                        mode_reg   <= OUT_RAW;
                        stat_reg   <= STAT_CAL;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                S_K_MUL: prod_reg <= mul_p;
                S_K_WR: begin
                    case (kstep_reg)
                        2'd0:    tt_reg <= prod_reg[MUL_W-1:0];
                        2'd1:    nn_reg <= prod_reg[MUL_W-1:0];
                        default: k_reg  <= prod_reg;
                    endcase
                    kstep_reg <= kstep_reg + 1'b1;
                end
                S_MV_MUL: prod_reg <= mul_p;
                S_MV_ADD: begin
                    acc_reg <= acc_step;
                    if (sub_reg == MV_LAST) begin
                        sub_reg    <= '0;
                        moving_reg <= moving_reg || acc_pos;
                        if (ax_reg == AXIS_Z) begin
                            ax_reg <= '0;
                            if (moving_reg || acc_pos)
                                stat_reg <= STAT_MOTION;
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end else begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (ax_reg == AXIS_Z) begin
                            ax_reg   <= '0;
                            mode_reg <= OUT_CORR;
                            stat_reg <= STAT_COMPLETE;
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == S_EMIT) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_EMIT) && out_free) begin
            out_status_reg <= stat_reg;
            out_data_reg   <= emit_data;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;

endmodule

[dv/gyro_bias_calibrator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_checker: result predictor and comparator
// Watches the register port and both streams, keeps its own copy of the
// calibration state, and checks every result beat against the oldest
// predicted one, field by field.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [gbc_pkg::DATA_W-1:0]    s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [gbc_pkg::DATA_W-1:0]    m_axis_tdata,
    input  logic [gbc_pkg::STAT_W-1:0]    m_axis_tuser,
    output int                            fail_count,
    output int                            pending
);
    import gbc_pkg::*;

    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [SAMPLE_W-1:0] rate [NUM_AXES];
    } gyro_result_t;

    gyro_result_t result_fifo [$];

    // shadow of the block's registers and calibration state
    logic [COUNT_W-1:0] cal_samples;
    logic [TH_W-1:0]    motion_th;
    longint             yaw_ofs;
    longint             axis_sum [NUM_AXES];
    longint unsigned    axis_sq_sum [NUM_AXES];
    longint             zero_ofs [NUM_AXES];
    longint unsigned    samples_left;
    bit                 calibrating;
    bit                 calibrated;

    int status_seen [6];

    function automatic logic [SAMPLE_W-1:0] clamp_rate(input longint v);
        if (v > 64'sd8388607)
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        if (v < -64'sd8388608)
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic longint unsigned cal_count();
        return (cal_samples == '0) ? 64'd1 : 64'(cal_samples);
    endfunction

    task automatic clear_sums();
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_sum[i]    = 0;
            axis_sq_sum[i] = 0;
        end
        samples_left = cal_count();
    endtask

    // n*sumsq - sum^2 > t^2*n*(n-1); the threshold term wraps at 64 bits
    function automatic bit axis_moving(input int i, input longint unsigned n);
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        logic [63:0]     th_term;
        longint unsigned mag;
        if (motion_th == '0 || n < 2)
            return 1'b0;
        mag     = (axis_sum[i] < 0) ? longint'(-axis_sum[i]) : axis_sum[i];
        th_term = 64'(motion_th);
        th_term = th_term * th_term;
        th_term = th_term * n;
        th_term = th_term * (n - 1);
        lhs     = 128'(n) * 128'(axis_sq_sum[i]);
        rhs     = 128'(mag) * 128'(mag) + 128'(th_term);
        return lhs > rhs;
    endfunction

    // mean rounded to nearest, ties away from zero
    function automatic longint mean_round(input longint s, input longint unsigned n);
        longint unsigned q;
        q = ((s < 0 ? longint'(-s) : s) + n / 2) / n;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_beat(input logic [1:0] op, input logic [DATA_W-1:0] d);
        longint          raw [NUM_AXES];
        longint unsigned n;
        longint unsigned mag;
        bit              moving;
        gyro_result_t    r;
        for (int i = 0; i < NUM_AXES; i++)
            raw[i] = longint'(signed'(d[i*SAMPLE_W +: SAMPLE_W]));
        r.status = STAT_CMD_DONE;
        for (int i = 0; i < NUM_AXES; i++)
            r.rate[i] = '0;
        case (kind_t'(op))
            KIND_RESTART: begin
                for (int i = 0; i < NUM_AXES; i++)
                    zero_ofs[i] = 0;
                clear_sums();
                calibrating = 1'b1;
                calibrated  = 1'b0;
            end
            KIND_LOAD: begin
                for (int i = 0; i < NUM_AXES; i++)
                    zero_ofs[i] = raw[i];
                calibrated  = 1'b1;
                calibrating = 1'b0;
            end
            KIND_SAMPLE: begin
                if (calibrating) begin
                    n = cal_count();
                    for (int i = 0; i < NUM_AXES; i++) begin
                        mag = (raw[i] < 0) ? longint'(-raw[i]) : raw[i];
                        axis_sum[i]    += raw[i];
                        axis_sq_sum[i] += mag * mag;
                    end
                    if (samples_left <= 1) begin
                        moving = 1'b0;
                        for (int i = 0; i < NUM_AXES; i++)
                            if (axis_moving(i, n))
                                moving = 1'b1;
                        if (moving) begin
                            clear_sums();
                            r.status = STAT_MOTION;
                        end else begin
                            for (int i = 0; i < NUM_AXES; i++)
                                zero_ofs[i] = mean_round(axis_sum[i], n);
                            zero_ofs[2] = longint'(signed'(clamp_rate(zero_ofs[2] - yaw_ofs)));
                            calibrating  = 1'b0;
                            calibrated   = 1'b1;
                            samples_left = 0;
                            r.status     = STAT_COMPLETE;
                        end
                    end else begin
                        samples_left--;
                        r.status = STAT_CAL;
                    end
                end else begin
                    r.status = calibrated ? STAT_CORRECTED : STAT_RAW;
                end
                for (int i = 0; i < NUM_AXES; i++)
                    r.rate[i] = clamp_rate((calibrated && r.status != STAT_MOTION
                                            && r.status != STAT_CAL)
                                           ? raw[i] - zero_ofs[i] : raw[i]);
            end
            default: ;  // unused code: no state change
        endcase
        result_fifo.push_back(r);
    endtask

    task automatic check_beat();
        gyro_result_t exp_r;
        string        names [NUM_AXES] = '{"out_x", "out_y", "out_z"};
        if (result_fifo.size() == 0) begin
            $error("result beat with nothing expected: status %0d data %h",
                   m_axis_tuser, m_axis_tdata);
            fail_count++;
            return;
        end
        exp_r = result_fifo.pop_front();
        if (exp_r.status < 6)
            status_seen[exp_r.status]++;
        if (m_axis_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
            fail_count++;
        end
        for (int i = 0; i < NUM_AXES; i++)
            if (m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] !== exp_r.rate[i]) begin
                $error("%s: expected %0d, got %0d", names[i],
                       signed'(exp_r.rate[i]),
                       signed'(m_axis_tdata[i*SAMPLE_W +: SAMPLE_W]));
                fail_count++;
            end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples = CAL_SAMPLES_RST;
            motion_th   = '0;
            yaw_ofs     = 0;
            for (int i = 0; i < NUM_AXES; i++)
                zero_ofs[i] = 0;
            clear_sums();
            calibrating = 1'b1;
            calibrated  = 1'b0;
            result_fifo.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            if (cfg_we) begin
                case (cfg_index)
                    REG_CAL_SAMPLES: begin
                        cal_samples = cfg_wdata;
                        if (calibrating)
                            clear_sums();
                    end
                    REG_MOTION_TH:  motion_th = cfg_wdata;
                    REG_YAW_OFFSET: yaw_ofs = longint'(signed'(cfg_wdata));
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_beat(s_axis_tuser, s_axis_tdata);
        end
        pending <= result_fifo.size();
    end

endmodule

[dv/gyro_bias_calibrator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_core_tb: stimulus and verdict for the bias calibrator
// Directed beats hit sample extremes, saturation, every operation and odd
// counts, then random phases reprogramme the registers and run calibrations
// of quiet and moving data under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_core_tb;
    import gbc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 600;

    localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7fffff;
    localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;

    int fail_count;
    int pending;
    int beats_sent;
    int phases;
    int burst_left;
    bit no_gaps;
    int hold_req;
    int hold_seen;
    int hold_cnt;
    int rx_mode;
    int rx_mode_cnt;
    longint cycles;

    gyro_bias_calibrator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    gyro_bias_calibrator_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stall pattern, redrawn when its counter runs out; long hold on request
    initial begin
        m_axis_tready = 1'b0;
        hold_seen = 0;
        hold_cnt = 0;
        rx_mode = 0;
        rx_mode_cnt = 0;
    end

    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_cnt == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_cnt <= 32;
            end else begin
                rx_mode_cnt <= rx_mode_cnt - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_rate();
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [SAMPLE_W-1:0] x,
                             input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {z, y, x};
        // inputs settle after the edge, so tready is stable at the falling edge
        do @(negedge aclk); while (!s_axis_tready);
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] cal, input logic [CFG_W-1:0] th,
                                  input logic [CFG_W-1:0] yaw);
        cfg_we <= 1'b1; cfg_index <= REG_CAL_SAMPLES; cfg_wdata <= cal;
        @(posedge aclk);
        cfg_index <= REG_MOTION_TH; cfg_wdata <= th;
        @(posedge aclk);
        cfg_index <= REG_YAW_OFFSET; cfg_wdata <= yaw;
        @(posedge aclk);
        // out-of-range index must be ignored
        cfg_index <= REG_UNUSED; cfg_wdata <= CFG_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // bias plus uniform noise, or now and then a fully random rate
    function automatic logic [SAMPLE_W-1:0] noisy_rate(input int bias, input int amp);
        if ($urandom_range(0, 19) == 0)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'(bias + $urandom_range(0, 2 * amp) - amp);
    endfunction

    task automatic run_phase();
        int cal;
        int th;
        int bias [3];
        int amp;
        int n_beats;
        int pick;
        pick = $urandom_range(0, 19);
        cal = (pick < 3) ? 0 : (pick < 5) ? 1 : (pick == 5) ? 30 : $urandom_range(2, 12);
        pick = $urandom_range(0, 9);
        th = (pick < 3) ? 0 : (pick == 3) ? 16'hffff : $urandom_range(1, 1500);
        pick = $urandom_range(0, 9);
        write_settings(CFG_W'(cal), CFG_W'(th),
                       (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7fff : CFG_W'($urandom));
        foreach (bias[i])
            bias[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16000000) - 8000000
                                                  : $urandom_range(0, 40000) - 20000;
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50000) : $urandom_range(0, 1200);
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0)
            send_beat(OP_RESTART, rand_rate(), rand_rate(), rand_rate());
        else
            send_beat(OP_LOAD, noisy_rate(bias[0], amp), noisy_rate(bias[1], amp),
                      noisy_rate(bias[2], amp));
        n_beats = (cal == 0 ? 1 : cal) * $urandom_range(1, 3) + $urandom_range(2, 10);
        for (int k = 0; k < n_beats; k++) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send_beat(KIND_NOP, rand_rate(), rand_rate(), rand_rate());
            else if (pick == 1)
                send_beat(OP_LOAD, rand_rate(), rand_rate(), rand_rate());
            else if (pick == 2)
                send_beat(OP_RESTART, rand_rate(), rand_rate(), rand_rate());
            else
                send_beat(OP_SAMPLE, noisy_rate(bias[0], amp), noisy_rate(bias[1], amp),
                          noisy_rate(bias[2], amp));
        end
        wait_drained();
        phases++;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CAL_SAMPLES;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_SAMPLE;
        hold_req = 0;
        beats_sent = 0;
        phases = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short calibration over extreme samples, then corrected output
        write_settings(16'd3, 16'd0, 16'd0);
        send_beat(OP_SAMPLE, S_MAX, S_MIN, 24'd1);
        send_beat(OP_SAMPLE, S_MIN, S_MAX, 24'hfffffe);
        send_beat(OP_SAMPLE, 24'd1, 24'd2, 24'd3);
        send_beat(OP_SAMPLE, S_MAX, S_MIN, 24'd0);
        send_beat(KIND_NOP, S_MAX, S_MAX, S_MAX);
        // loaded zeros at the extremes drive the output into saturation
        send_beat(OP_LOAD, S_MAX, S_MIN, S_MAX);
        send_beat(OP_SAMPLE, S_MIN, S_MAX, S_MIN);
        send_beat(OP_SAMPLE, S_MAX, S_MIN, S_MAX);
        wait_drained();
        // zero count acts as one; yaw offset pushes the Z zero past the rail
        write_settings(16'd0, 16'hffff, 16'h8000);
        send_beat(OP_RESTART, S_MAX, S_MAX, S_MAX);
        send_beat(OP_SAMPLE, 24'd100, 24'hffff00, S_MAX);
        send_beat(OP_SAMPLE, S_MIN, S_MIN, S_MIN);
        send_beat(OP_LOAD, 24'd0, 24'd0, 24'd0);
        wait_drained();
        write_settings(16'hffff, 16'd0, 16'h7fff);
        send_beat(OP_SAMPLE, S_MAX, 24'd0, S_MIN);
        wait_drained();
        // moving data over a one-count threshold restarts, still data completes
        write_settings(16'd2, 16'd1, 16'h7fff);
        send_beat(OP_RESTART, 24'd0, 24'd0, 24'd0);
        send_beat(OP_SAMPLE, 24'd1000, 24'hfffc18, 24'd5);
        send_beat(OP_SAMPLE, 24'hfffc18, 24'd1000, 24'hfffffb);
        send_beat(OP_SAMPLE, 24'd7, 24'd7, S_MIN);
        send_beat(OP_SAMPLE, 24'd7, 24'd7, S_MIN);
        send_beat(OP_SAMPLE, 24'd8, 24'd9, 24'd10);
        wait_drained();

        while (beats_sent < ITEM_TARGET) begin
            // one phase with a long receiver hold while the sender keeps going
            if (phases == 3)
                hold_req <= hold_req + 1;
            run_phase();
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        $display("%0d beats over %0d random phases; %0d calibrations completed,",
                 beats_sent, phases, chk.status_seen[STAT_COMPLETE]);
        $display("%0d motion restarts, %0d corrected and %0d raw samples",
                 chk.status_seen[STAT_MOTION], chk.status_seen[STAT_CORRECTED],
                 chk.status_seen[STAT_RAW]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
